// ===== hdl/bldc_six_step_commutator_top_assert.svh =====
// ----------------------------------------------------------------------------
// bldc six-step commutator assertion macros
// concurrent assertion wrappers clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef BLDC_SIX_STEP_COMMUTATOR_TOP_ASSERT_SVH
`define BLDC_SIX_STEP_COMMUTATOR_TOP_ASSERT_SVH

// checked only outside reset
`define BSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define BSSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/bssc_pkg.sv =====
// ----------------------------------------------------------------------------
// bssc_pkg
// shared types, constants and step tables of the six-step commutator
// ----------------------------------------------------------------------------
`default_nettype none

package bssc_pkg;

  localparam int unsigned STEP_COUNT = 6;
  localparam int unsigned STEP_W     = $clog2(STEP_COUNT);

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(STEP_COUNT - 1);
  localparam logic [6:0]        DUTY_FULL  = 7'd100;
  localparam logic [16:0]       PERIOD_MAX = 17'd65536;
  localparam logic [2:0]        MARK_CODE  = 3'd1;

  // floor(x / 100) for x below 2**23: (x * ceil(2**30 / 100)) >> 30
  localparam logic [23:0] RECIP_MUL   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    STAGE_STARTUP = 2'd0,
    STAGE_ALIGN   = 2'd1,
    STAGE_RUN     = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_DRIVE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_STARTUP_DUTY   = 3'd0,
    REG_ALIGN_DUTY     = 3'd1,
    REG_RUN_DUTY       = 3'd2,
    REG_STEP_THRESHOLD = 3'd3,
    REG_ROUND_LIMIT    = 3'd4,
    REG_ALIGN_FACTOR   = 3'd5,
    REG_PWM_PERIOD     = 3'd6,
    REG_SEQUENCE_CODES = 3'd7
  } reg_e;

  typedef struct packed {
    logic [6:0]  startup_duty;
    logic [6:0]  align_duty;
    logic [6:0]  run_duty;
    logic [15:0] step_threshold;
    logic [7:0]  round_limit;
    logic [3:0]  align_factor;
    logic [16:0] pwm_period;
    logic [17:0] sequence_codes;
  } cfg_t;

  // step command leaving the sequencer
  typedef struct packed {
    cmd_e              kind;
    logic [STEP_W-1:0] step;
    logic [16:0]       period;
    logic [6:0]        duty;
    stage_e            stage;
    logic [STEP_W-1:0] index;
    logic              did;
    logic              mark;
  } cmd_t;

  // step command with period times duty
  typedef struct packed {
    cmd_e              kind;
    logic [STEP_W-1:0] step;
    logic [16:0]       period;
    logic [22:0]       product;
    stage_e            stage;
    logic [STEP_W-1:0] index;
    logic              did;
    logic              mark;
  } prod_t;

  typedef struct packed {
    logic [16:0]       high_a;
    logic [16:0]       high_b;
    logic [16:0]       high_c;
    logic [16:0]       low_a;
    logic [16:0]       low_b;
    logic [16:0]       low_c;
    stage_e            stage;
    logic [STEP_W-1:0] index;
    logic [15:0]       center;
    logic              did;
    logic              mark;
  } res_t;

  // phase driven high per step: a a b b c c
  function automatic logic [1:0] high_phase(input logic [STEP_W-1:0] s);
    logic [1:0] p;
    case (s)
      3'd0, 3'd1: p = 2'd0;
      3'd2, 3'd3: p = 2'd1;
      default:    p = 2'd2;
    endcase
    return p;
  endfunction

  // phase pulled low per step: b c c a a b
  function automatic logic [1:0] low_phase(input logic [STEP_W-1:0] s);
    logic [1:0] p;
    case (s)
      3'd0, 3'd5: p = 2'd1;
      3'd1, 3'd2: p = 2'd2;
      default:    p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s);
    return (s >= LAST_STEP) ? '0 : STEP_W'(s + 1'b1);
  endfunction

  function automatic logic [2:0] code_of(input logic [17:0] codes,
                                         input logic [STEP_W-1:0] s);
    logic [2:0] c;
    case (s)
      3'd0:    c = codes[2:0];
      3'd1:    c = codes[5:3];
      3'd2:    c = codes[8:6];
      3'd3:    c = codes[11:9];
      3'd4:    c = codes[14:12];
      default: c = codes[17:15];
    endcase
    return c;
  endfunction

  function automatic logic [6:0] sat_duty(input logic [6:0] d);
    return (d > DUTY_FULL) ? DUTY_FULL : d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bssc_seq.sv =====
// ----------------------------------------------------------------------------
// bssc_seq
// stage, step index, pacing and round counters; issues one step command per tick
// ----------------------------------------------------------------------------
`default_nettype none

module bssc_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bssc_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic          stop_i,
  input  logic [2:0]    code_i,
  output logic          valid_o,
  input  logic          ready_i,
  output bssc_pkg::cmd_t cmd_o
);
  import bssc_pkg::*;

  stage_e            stage_q, stage_d;
  logic [STEP_W-1:0] index_q, index_d;
  logic [15:0]       pace_q, pace_d;
  logic [7:0]        su_rounds_q, su_rounds_d;
  logic [11:0]       al_rounds_q, al_rounds_d;
  logic              valid_q;
  cmd_t              cmd_q, cmd_d;

  logic              accept;
  logic              fire;
  logic [STEP_W-1:0] nxt;
  logic              code_hit;
  logic [11:0]       align_limit;
  logic [11:0]       rounds_cur;
  logic [11:0]       limit_cur;
  logic              round_done;
  logic [16:0]       per_sat;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign fire        = pace_q >= cfg_i.step_threshold;
  assign nxt         = next_step(index_q);
  assign code_hit    = code_i == code_of(cfg_i.sequence_codes, nxt);
  assign align_limit = {4'd0, cfg_i.round_limit} * {8'd0, cfg_i.align_factor};
  assign rounds_cur  = (stage_q == STAGE_ALIGN) ? al_rounds_q : {4'd0, su_rounds_q};
  assign limit_cur   = (stage_q == STAGE_ALIGN) ? align_limit : {4'd0, cfg_i.round_limit};
  assign round_done  = (index_q == LAST_STEP) && (rounds_cur >= limit_cur);
  assign per_sat     = (cfg_i.pwm_period > PERIOD_MAX) ? PERIOD_MAX : cfg_i.pwm_period;

  // stage transitions
  always_comb begin
    stage_d = stage_q;
    if (accept) begin
      if (stop_i) begin
        stage_d = STAGE_STARTUP;
      end else begin
        unique case (stage_q)
          STAGE_STARTUP: if (fire && round_done) stage_d = STAGE_ALIGN;
          STAGE_ALIGN:   if (fire && round_done) stage_d = STAGE_RUN;
          default:       stage_d = stage_q;
        endcase
      end
    end
  end

  // counters and step command
  always_comb begin
    index_d     = index_q;
    pace_d      = pace_q;
    su_rounds_d = su_rounds_q;
    al_rounds_d = al_rounds_q;
    cmd_d       = cmd_q;
    if (accept) begin
      cmd_d.kind   = CMD_HOLD;
      cmd_d.step   = index_q;
      cmd_d.period = per_sat;
      cmd_d.duty   = '0;
      cmd_d.did    = 1'b0;
      cmd_d.mark   = 1'b0;
      if (stop_i) begin
        cmd_d.kind = CMD_CLEAR;
      end else begin
        case (stage_q) inside
          STAGE_STARTUP, STAGE_ALIGN: begin
            if (!fire) begin
              pace_d = pace_q + 16'd1;
            end else begin
              pace_d     = '0;
              cmd_d.kind = CMD_DRIVE;
              cmd_d.duty = sat_duty((stage_q == STAGE_ALIGN) ? cfg_i.align_duty
                                                             : cfg_i.startup_duty);
              cmd_d.did  = 1'b1;
              if (round_done) begin
                // stage ends, index stays on the last step
                if (stage_q == STAGE_ALIGN) al_rounds_d = '0;
                else                        su_rounds_d = '0;
              end else begin
                if (index_q == LAST_STEP) begin
                  if (stage_q == STAGE_ALIGN) al_rounds_d = al_rounds_q + 12'd1;
                  else                        su_rounds_d = su_rounds_q + 8'd1;
                end
                index_d = nxt;
              end
            end
          end
          default: begin
            if (code_hit) begin
              index_d    = nxt;
              cmd_d.kind = CMD_DRIVE;
              cmd_d.step = nxt;
              cmd_d.duty = sat_duty(cfg_i.run_duty);
              cmd_d.did  = 1'b1;
              cmd_d.mark = code_i == MARK_CODE;
            end
          end
        endcase
      end
      cmd_d.stage = stage_d;
      cmd_d.index = index_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STAGE_STARTUP;
      index_q     <= '0;
      pace_q      <= '0;
      su_rounds_q <= '0;
      al_rounds_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      index_q     <= index_d;
      pace_q      <= pace_d;
      su_rounds_q <= su_rounds_d;
      al_rounds_q <= al_rounds_d;
      if (ready_o) valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

`default_nettype wire

// ===== hdl/bssc_mult.sv =====
// ----------------------------------------------------------------------------
// bssc_mult
// period times duty percent, registered
// ----------------------------------------------------------------------------
`default_nettype none

module bssc_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bssc_pkg::cmd_t  cmd_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bssc_pkg::prod_t prod_o
);
  import bssc_pkg::*;

  logic        valid_q;
  prod_t       prod_q;
  logic [23:0] full;

  assign ready_o = !valid_q || ready_i;

  // at most 65536 * 100, fits 23 bits
  assign full = {7'd0, cmd_i.period} * {17'd0, cmd_i.duty};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q.kind    <= cmd_i.kind;
      prod_q.step    <= cmd_i.step;
      prod_q.period  <= cmd_i.period;
      prod_q.product <= full[22:0];
      prod_q.stage   <= cmd_i.stage;
      prod_q.index   <= cmd_i.index;
      prod_q.did     <= cmd_i.did;
      prod_q.mark    <= cmd_i.mark;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

// ===== hdl/bssc_drive.sv =====
// ----------------------------------------------------------------------------
// bssc_drive
// divide by 100 and update the held channel compares; result register
// ----------------------------------------------------------------------------
`default_nettype none

module bssc_drive (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bssc_pkg::prod_t prod_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bssc_pkg::res_t  res_o
);
  import bssc_pkg::*;

  logic        valid_q;
  res_t        res_q, res_d;
  logic [46:0] scaled;
  logic [16:0] quot;
  logic [1:0]  hp, lp;

  assign ready_o = !valid_q || ready_i;

  assign scaled = {1'b0, prod_i.product} * {23'd0, RECIP_MUL};
  assign quot   = scaled[RECIP_SHIFT +: 17];
  assign hp     = high_phase(prod_i.step);
  assign lp     = low_phase(prod_i.step);

  always_comb begin
    res_d       = res_q;
    res_d.stage = prod_i.stage;
    res_d.index = prod_i.index;
    res_d.did   = prod_i.did;
    res_d.mark  = prod_i.mark;
    case (prod_i.kind)
      CMD_CLEAR, CMD_DRIVE: begin
        res_d.high_a = '0;
        res_d.high_b = '0;
        res_d.high_c = '0;
        res_d.low_a  = '0;
        res_d.low_b  = '0;
        res_d.low_c  = '0;
        res_d.center = '0;
        if (prod_i.kind == CMD_DRIVE) begin
          case (hp)
            2'd0:    res_d.high_a = quot;
            2'd1:    res_d.high_b = quot;
            default: res_d.high_c = quot;
          endcase
          case (lp)
            2'd0:    res_d.low_a = prod_i.period;
            2'd1:    res_d.low_b = prod_i.period;
            default: res_d.low_c = prod_i.period;
          endcase
          // only one high side is nonzero, so it is the largest
          res_d.center = quot[16:1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      if (valid_i) res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== hdl/bldc_six_step_commutator_top.sv =====
// a tick transaction is registered in the sequencer, then in the multiply stage, then in the drive stage
// throughput: one tick per cycle while the result stream is not stalled, three registered stages (sequencer,
//   multiply, divide by 100 with channel update) each hand off through their own ready
// reset: start-up stage, step 0, pacing and round counters zero, all compares zero,
//   configuration registers at their documented defaults
// ----------------------------------------------------------------------------
// bldc_six_step_commutator_top
// six-step trapezoidal commutator: open-loop start-up and align, then
// back-emf comparator driven run, producing six channel compare values
// ----------------------------------------------------------------------------
`default_nettype none

`include "bldc_six_step_commutator_top_assert.svh"

module bldc_six_step_commutator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration writes
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [17:0]  cfg_data_i,
  // tick stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // comp_a, comp_b, comp_c, zero pad
  input  logic         s_axis_tuser,   // func (1 = stop motor)
  // result stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // high_a_compare, high_b_compare, high_c_compare, low_a_compare,
  // low_b_compare, low_c_compare, stage_code, step_index, half_compare,
  // commutated, revolution_mark, zero pad
  output logic [127:0] m_axis_tdata
);
  import bssc_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  prod_t prod;
  res_t  res;
  logic  seq_valid, seq_ready;
  logic  mult_valid, mult_ready;
  logic  drv_ready;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_duty   <= 7'd50;
      cfg_q.align_duty     <= 7'd50;
      cfg_q.run_duty       <= 7'd25;
      cfg_q.step_threshold <= 16'd1;
      cfg_q.round_limit    <= 8'd5;
      cfg_q.align_factor   <= 4'd2;
      cfg_q.pwm_period     <= 17'd3600;
      cfg_q.sequence_codes <= 18'd156877;   // codes 5 1 3 2 6 4
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_STARTUP_DUTY:   cfg_q.startup_duty   <= cfg_data_i[6:0];
        REG_ALIGN_DUTY:     cfg_q.align_duty     <= cfg_data_i[6:0];
        REG_RUN_DUTY:       cfg_q.run_duty       <= cfg_data_i[6:0];
        REG_STEP_THRESHOLD: cfg_q.step_threshold <= cfg_data_i[15:0];
        REG_ROUND_LIMIT:    cfg_q.round_limit    <= cfg_data_i[7:0];
        REG_ALIGN_FACTOR:   cfg_q.align_factor   <= cfg_data_i[3:0];
        REG_PWM_PERIOD:     cfg_q.pwm_period     <= cfg_data_i[16:0];
        REG_SEQUENCE_CODES: cfg_q.sequence_codes <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: state update, one step command per tick transaction
  bssc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .stop_i  (s_axis_tuser),
    .code_i  (s_axis_tdata[2:0]),   // c*4 + b*2 + a
    .valid_o (seq_valid),
    .ready_i (seq_ready),
    .cmd_o   (cmd)
  );

  // stage 2: period times duty
  bssc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seq_valid),
    .ready_o (seq_ready),
    .cmd_i   (cmd),
    .valid_o (mult_valid),
    .ready_i (mult_ready),
    .prod_o  (prod)
  );

  // stage 3: scale to compare, held channel state doubles as output register
  bssc_drive u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .ready_o (mult_ready),
    .prod_i  (prod),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign drv_ready = mult_ready;

  assign m_axis_tdata = {3'd0, res.mark, res.did, res.center, res.index, res.stage,
                         res.low_c, res.low_b, res.low_a,
                         res.high_c, res.high_b, res.high_a};

  // ---- assertions ----
  logic [2:0] high_nz, low_nz;
  assign high_nz = {|res.high_c, |res.high_b, |res.high_a};
  assign low_nz  = {|res.low_c, |res.low_b, |res.low_a};

  `BSSC_ASSERT(a_one_high, $countones(high_nz) <= 1, "more than one high side driven")
  `BSSC_ASSERT(a_one_low, $countones(low_nz) <= 1, "more than one low side driven")
  `BSSC_ASSERT(a_center, res.center == 16'((res.high_a | res.high_b | res.high_c) >> 1), "pulse center mismatch")
  `BSSC_ASSERT(a_mark_run, m_axis_tvalid && res.mark |-> res.did && res.stage == STAGE_RUN, "revolution mark outside run step")
  `BSSC_ASSERT(a_drv_stall, m_axis_tvalid && !m_axis_tready |-> !drv_ready, "drive stage advanced while stalled")

endmodule

`default_nettype wire
